FILE: hdl/priority_round_robin_task_ring_core_assert.svh
// Assertion macros shared by the task ring RTL.
// Depends on nothing; each macro expands to a concurrent assertion.
`ifndef PRIORITY_ROUND_ROBIN_TASK_RING_CORE_ASSERT_SVH
`define PRIORITY_ROUND_ROBIN_TASK_RING_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// ante holds in a cycle -> cons holds in the same cycle
`define PRRT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("task ring check failed");

// ante holds in a cycle -> cons holds in the next cycle
`define PRRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("task ring check failed");

`else

`define PRRT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PRRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/prrt_pkg.sv
// Shared constants, codes and structs for the task ring scheduler.
// No dependencies; used by prrt_table and the core.
package prrt_pkg;

  localparam int MAX_TASKS = 16;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int ID_W      = 8;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 2;
  localparam int HC_W      = SLOT_W + 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_CREATE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_KILL   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_RAISE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_LOWER  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_STOP   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_EXIT   = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DEAD     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

  // table write commands for one cycle
  typedef struct packed {
    logic              next_a_we;
    logic [SLOT_W-1:0] next_a_addr;
    logic [SLOT_W-1:0] next_a_data;
    logic              next_b_we;
    logic [SLOT_W-1:0] next_b_addr;
    logic [SLOT_W-1:0] next_b_data;
    logic              alloc_we;     // used=1, id written, high=0
    logic [SLOT_W-1:0] alloc_addr;
    logic [ID_W-1:0]   alloc_id;
    logic              free_we;      // used=0, high=0
    logic [SLOT_W-1:0] free_addr;
    logic              high_we;
    logic [SLOT_W-1:0] high_addr;
    logic              high_val;
    logic              shell_high_we;
    logic              shell_high_val;
  } tbl_wr_t;

  // fields of the slot at the read pointer
  typedef struct packed {
    logic              used;
    logic [ID_W-1:0]   id;
    logic              high;
    logic [SLOT_W-1:0] next;
  } tbl_rd_t;

  // lowest free slot
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } tbl_free_t;

endpackage

FILE: hdl/priority_round_robin_task_ring_core.sv
// Top level of the two-level priority round-robin task ring scheduler.
// Depends on prrt_pkg, prrt_table and priority_round_robin_task_ring_core_assert.svh.
//
// Usage:
//   A request beat is taken at a rising edge with start high and busy low; it
//   carries req_type_i and task_id_i. Exactly one result beat follows, shown on
//   status_o / result_id_o / run_valid_o for a single cycle with done_o high.
//   The receiver cannot hold results off; busy is already low in that cycle,
//   so the next request may be taken alongside the result beat.
// Request flow (one ring slot visited per cycle):
//   create                  : S_FREE links the lowest free slot after current
//   unused request codes    : answered straight from idle
//   kill / raise / lower    : S_FIND walks for the id (1..16 slots), S_APPLY
//   stop                    : S_FIND, S_APPLY, S_PICK walks to a high slot, S_FIN
//   exit                    : S_FIND, S_APPLY, S_PRED walks to the predecessor
//                             and unlinks, S_PICK, S_FIN; each walk is at most 15 steps
//   lookup miss             : S_FIND walks the whole ring
// Reset: the ring holds only the shell in slot 0 (id 0, low priority, linked
//   to itself), the shell is current and the high count is zero. No clearing
//   pass is needed; the block comes out of reset idle, ready to take a request.
module priority_round_robin_task_ring_core import prrt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [ID_W-1:0]   task_id_i,
  output logic              done_o,
  output logic [STAT_W-1:0] status_o,
  output logic [ID_W-1:0]   result_id_o,
  output logic              run_valid_o
);

`include "priority_round_robin_task_ring_core_assert.svh"

  // Sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FREE  = 7'b0000010, // create: link lowest free slot after current
    S_FIND  = 7'b0000100, // walk ring from current looking for the id
    S_APPLY = 7'b0001000, // act on the found slot
    S_PRED  = 7'b0010000, // exit: walk to the predecessor and unlink
    S_PICK  = 7'b0100000, // first high slot from the start point
    S_FIN   = 7'b1000000  // chosen slot at pointer: read id, report
  } state_e;

  localparam logic [SLOT_W-1:0] LAST_STEP = SLOT_W'(MAX_TASKS - 1);

  state_e state_q, state_d;

  // request beat
  logic [REQ_W-1:0]  req_q, req_d;
  logic [ID_W-1:0]   id_q, id_d;

  // walker
  logic [SLOT_W-1:0] p_q, p_d;        // table read pointer
  logic [SLOT_W-1:0] cnt_q, cnt_d;    // steps taken in the current walk
  logic [SLOT_W-1:0] s_q, s_d;        // slot found by the lookup
  logic [SLOT_W-1:0] nxt_q, nxt_d;    // successor of the found slot
  logic [SLOT_W-1:0] start_q, start_d; // start point of the high search
  logic              high_s_q, high_s_d;

  // scheduler state
  logic [SLOT_W-1:0] cur_q, cur_d;
  logic [HC_W-1:0]   hc_q, hc_d;
  logic [HC_W-1:0]   hc_step;

  // result beat
  logic              done_q, done_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [ID_W-1:0]   rid_q, rid_d;
  logic              run_q, run_d;

  // table
  tbl_wr_t              tbl_wr;
  tbl_rd_t              rd;
  tbl_free_t            free;
  logic [MAX_TASKS-1:0] used_vec;

  logic hit;
  logic last_step;
  logic pred_match;

  prrt_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (p_q),
    .wr_i      (tbl_wr),
    .rd_o      (rd),
    .used_o    (used_vec),
    .free_o    (free)
  );

  assign busy       = (state_q != S_IDLE);
  assign hit        = rd.used && (rd.id == id_q);
  assign last_step  = (cnt_q == LAST_STEP);
  assign pred_match = (rd.next == s_q);

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    id_d     = id_q;
    p_d      = p_q;
    cnt_d    = cnt_q;
    s_d      = s_q;
    nxt_d    = nxt_q;
    start_d  = start_q;
    high_s_d = high_s_q;
    cur_d    = cur_q;
    hc_d     = hc_q;
    hc_step  = hc_q;
    done_d   = 1'b0;
    status_d = status_q;
    rid_d    = rid_q;
    run_d    = run_q;
    tbl_wr   = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d = req_type_i;
          id_d  = task_id_i;
          p_d   = cur_q;
          cnt_d = '0;
          case (req_type_i)
            REQ_CREATE: state_d = S_FREE;
            REQ_KILL, REQ_RAISE, REQ_LOWER, REQ_STOP, REQ_EXIT: state_d = S_FIND;
            default: begin
              // unused codes: plain ok beat
              done_d   = 1'b1;
              status_d = STAT_OK;
              rid_d    = '0;
              run_d    = 1'b0;
            end
          endcase
        end
      end

      S_FREE: begin
        // pointer sits on the current slot
        done_d  = 1'b1;
        rid_d   = '0;
        run_d   = 1'b0;
        state_d = S_IDLE;
        if (!free.found) begin
          status_d = STAT_FULL;
        end else begin
          status_d           = STAT_OK;
          tbl_wr.alloc_we    = 1'b1;
          tbl_wr.alloc_addr  = free.slot;
          tbl_wr.alloc_id    = id_q;
          tbl_wr.next_a_we   = 1'b1;
          tbl_wr.next_a_addr = free.slot;
          tbl_wr.next_a_data = rd.next;
          tbl_wr.next_b_we   = 1'b1;
          tbl_wr.next_b_addr = cur_q;
          tbl_wr.next_b_data = free.slot;
          cur_d              = free.slot;
        end
      end

      S_FIND: begin
        if (hit) begin
          s_d     = p_q;
          state_d = S_APPLY;
        end else if ((rd.next == cur_q) || last_step) begin
          done_d   = 1'b1;
          status_d = STAT_NOTFOUND;
          rid_d    = '0;
          run_d    = 1'b0;
          state_d  = S_IDLE;
        end else begin
          p_d   = rd.next;
          cnt_d = cnt_q + SLOT_W'(1);
        end
      end

      S_APPLY: begin
        // pointer sits on the found slot
        status_d = STAT_OK;
        rid_d    = '0;
        run_d    = 1'b0;
        case (req_q)
          REQ_KILL: begin
            rid_d   = id_q;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
          REQ_RAISE: begin
            if (!rd.high) begin
              tbl_wr.high_we   = 1'b1;
              tbl_wr.high_addr = s_q;
              tbl_wr.high_val  = 1'b1;
              hc_step          = hc_q + HC_W'(1);
              hc_d             = hc_step;
              // first high task drags the shell up with it
              if ((hc_step == HC_W'(1)) && used_vec[0]) begin
                tbl_wr.shell_high_we  = 1'b1;
                tbl_wr.shell_high_val = 1'b1;
                hc_d                  = hc_q + HC_W'(2);
              end
            end
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
          REQ_LOWER: begin
            if (rd.high) begin
              tbl_wr.high_we   = 1'b1;
              tbl_wr.high_addr = s_q;
              tbl_wr.high_val  = 1'b0;
              hc_step          = (hc_q != '0) ? hc_q - HC_W'(1) : hc_q;
              hc_d             = hc_step;
              // only the shell left high: drop it too
              if ((hc_step == HC_W'(1)) && used_vec[0]) begin
                tbl_wr.shell_high_we  = 1'b1;
                tbl_wr.shell_high_val = 1'b0;
                hc_d                  = '0;
              end
            end
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
          REQ_STOP: begin
            cur_d   = s_q;
            nxt_d   = rd.next;
            p_d     = rd.next;
            start_d = rd.next;
            cnt_d   = '0;
            state_d = S_PICK;
          end
          REQ_EXIT: begin
            cur_d    = s_q;
            nxt_d    = rd.next;
            high_s_d = rd.high;
            cnt_d    = '0;
            if (rd.next == s_q) begin
              // alone in the ring
              done_d   = 1'b1;
              status_d = STAT_DEAD;
              state_d  = S_IDLE;
            end else begin
              state_d = S_PRED;
            end
          end
          default: begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end

      S_PRED: begin
        if (pred_match || last_step) begin
          // unlink the exiting slot and free it
          tbl_wr.next_a_we   = 1'b1;
          tbl_wr.next_a_addr = pred_match ? p_q : rd.next;
          tbl_wr.next_a_data = nxt_q;
          tbl_wr.free_we     = 1'b1;
          tbl_wr.free_addr   = s_q;
          if (high_s_q && (hc_q != '0)) hc_d = hc_q - HC_W'(1);
          p_d     = nxt_q;
          start_d = nxt_q;
          cnt_d   = '0;
          state_d = S_PICK;
        end else begin
          p_d   = rd.next;
          cnt_d = cnt_q + SLOT_W'(1);
        end
      end

      S_PICK: begin
        if (rd.used && rd.high) begin
          state_d = S_FIN;
        end else if ((rd.next == start_q) || last_step) begin
          // no high task: fall back to the start point
          p_d     = start_q;
          state_d = S_FIN;
        end else begin
          p_d   = rd.next;
          cnt_d = cnt_q + SLOT_W'(1);
        end
      end

      S_FIN: begin
        cur_d    = p_q;
        done_d   = 1'b1;
        status_d = STAT_OK;
        rid_d    = rd.id;
        run_d    = 1'b1;
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cur_q   <= '0;
      hc_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      hc_q    <= hc_d;
      done_q  <= done_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    id_q     <= id_d;
    p_q      <= p_d;
    cnt_q    <= cnt_d;
    s_q      <= s_d;
    nxt_q    <= nxt_d;
    start_q  <= start_d;
    high_s_q <= high_s_d;
    status_q <= status_d;
    rid_q    <= rid_d;
    run_q    <= run_d;
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign result_id_o = rid_q;
  assign run_valid_o = run_q;

  // checks
  `PRRT_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o && !(start && !busy), !done_o)
  `PRRT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy && (req_type_i == REQ_CREATE), busy)
  `PRRT_ASSERT_SAME(a_run_ok, clk_i, rst_ni, done_o && run_valid_o, status_o == STAT_OK)
  `PRRT_ASSERT_SAME(a_err_clean, clk_i, rst_ni, done_o && (status_o != STAT_OK), (result_id_o == '0) && !run_valid_o)
  `PRRT_ASSERT_SAME(a_cur_used, clk_i, rst_ni, state_q == S_IDLE, used_vec[cur_q])

endmodule

FILE: hdl/prrt_table.sv
// Slot table of the task ring: used, id, priority and link per slot.
// Depends on prrt_pkg. One read port at a pointer, write commands per cycle.
module prrt_table import prrt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [SLOT_W-1:0]    rd_addr_i,
  input  tbl_wr_t              wr_i,
  output tbl_rd_t              rd_o,
  output logic [MAX_TASKS-1:0] used_o,
  output tbl_free_t            free_o
);

  logic [MAX_TASKS-1:0] used_q;
  logic [MAX_TASKS-1:0] high_q;
  logic [SLOT_W-1:0]    next_q [MAX_TASKS];
  logic [ID_W-1:0]      id_q   [MAX_TASKS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= {{(MAX_TASKS-1){1'b0}}, 1'b1};
      high_q <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        next_q[i] <= '0;
        id_q[i]   <= '0;
      end
    end else begin
      if (wr_i.next_a_we) next_q[wr_i.next_a_addr] <= wr_i.next_a_data;
      if (wr_i.next_b_we) next_q[wr_i.next_b_addr] <= wr_i.next_b_data;
      if (wr_i.alloc_we) begin
        used_q[wr_i.alloc_addr] <= 1'b1;
        high_q[wr_i.alloc_addr] <= 1'b0;
        id_q[wr_i.alloc_addr]   <= wr_i.alloc_id;
      end
      if (wr_i.free_we) begin
        used_q[wr_i.free_addr] <= 1'b0;
        high_q[wr_i.free_addr] <= 1'b0;
      end
      if (wr_i.high_we)       high_q[wr_i.high_addr] <= wr_i.high_val;
      if (wr_i.shell_high_we) high_q[0]              <= wr_i.shell_high_val;
    end
  end

  assign rd_o.used = used_q[rd_addr_i];
  assign rd_o.id   = id_q[rd_addr_i];
  assign rd_o.high = high_q[rd_addr_i];
  assign rd_o.next = next_q[rd_addr_i];
  assign used_o    = used_q;

  // lowest free slot: priority encoder, highest index first so lowest wins
  always_comb begin
    free_o = '0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_o.found = 1'b1;
        free_o.slot  = SLOT_W'(i);
      end
    end
  end

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for priority_round_robin_task_ring_core.
// Needs prrt_pkg and the core RTL; an in-bench copy of the ring state predicts
// every result beat, which is compared against the block's output.
`timescale 1ns / 1ps

module tb;
  import prrt_pkg::*;

  // request codes the block ignores (status ok, no result id)
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  localparam int QUIET_LIMIT   = 2000; // cycles with no beat before giving up
  localparam int SETTLE_CYCLES = 60;   // > worst-case request latency

  // one expected result beat
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   rid;
    logic              run;
  } sched_res_t;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              start      = 1'b0;
  logic              busy;
  logic [REQ_W-1:0]  req_type_i = REQ_CREATE;
  logic [ID_W-1:0]   task_id_i  = '0;
  logic              done_o;
  logic [STAT_W-1:0] status_o;
  logic [ID_W-1:0]   result_id_o;
  logic              run_valid_o;

  // predicted ring state
  logic              ring_used [MAX_TASKS];
  logic [ID_W-1:0]   ring_id   [MAX_TASKS];
  logic              ring_high [MAX_TASKS];
  logic [SLOT_W-1:0] ring_next [MAX_TASKS];
  logic [SLOT_W-1:0] cur_slot;
  int unsigned       high_cnt;

  sched_res_t pending_res_q[$];   // results owed by the block, oldest first

  int idle_pct = 29;              // sender idle probability per cycle, percent
  int beats_sent;
  int results_seen;
  int bad_results;
  int quiet_cycles;
  int req_count [8];
  int status_count [4];

  priority_round_robin_task_ring_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type_i),
    .task_id_i   (task_id_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .result_id_o (result_id_o),
    .run_valid_o (run_valid_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Walk the ring once from the current slot; first live slot with this id.
  function automatic int find_slot(logic [ID_W-1:0] id);
    logic [SLOT_W-1:0] p;
    p = cur_slot;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (ring_used[p] && ring_id[p] == id) return p;
      p = ring_next[p];
      if (p == cur_slot) break;
    end
    return -1;
  endfunction

  // First high slot in ring order from 'from', else 'from' itself.
  function automatic logic [SLOT_W-1:0] pick_high_from(logic [SLOT_W-1:0] from);
    logic [SLOT_W-1:0] p;
    p = from;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (ring_used[p] && ring_high[p]) return p;
      p = ring_next[p];
      if (p == from) break;
    end
    return from;
  endfunction

  // high count saturates at zero
  function automatic void drop_high_count();
    if (high_cnt > 0) high_cnt--;
  endfunction

  // Apply one request to the predicted ring and return the result it owes.
  function automatic sched_res_t predict_request(logic [REQ_W-1:0] req,
                                                 logic [ID_W-1:0] id);
    sched_res_t        res;
    int                s;
    int                free_slot;
    logic [SLOT_W-1:0] cur;
    logic [SLOT_W-1:0] nxt;
    logic [SLOT_W-1:0] pred;
    res.status = STAT_OK;
    res.rid    = '0;
    res.run    = 1'b0;
    free_slot  = -1;
    case (req)
      REQ_CREATE: begin
        for (int i = 0; i < MAX_TASKS; i++)
          if (!ring_used[i] && free_slot < 0) free_slot = i;
        if (free_slot < 0) begin
          res.status = STAT_FULL;
        end else begin
          // new low task goes in after the current one and becomes current
          ring_used[free_slot] = 1'b1;
          ring_id[free_slot]   = id;
          ring_high[free_slot] = 1'b0;
          ring_next[free_slot] = ring_next[cur_slot];
          ring_next[cur_slot]  = free_slot[SLOT_W-1:0];
          cur_slot             = free_slot[SLOT_W-1:0];
        end
      end
      REQ_KILL: begin
        s = find_slot(id);
        if (s < 0) res.status = STAT_NOTFOUND;
        else res.rid = id;
      end
      REQ_RAISE: begin
        s = find_slot(id);
        if (s < 0) begin
          res.status = STAT_NOTFOUND;
        end else if (!ring_high[s]) begin
          ring_high[s] = 1'b1;
          high_cnt++;
          // first high task drags the shell up too (counted twice if it is the shell)
          if (high_cnt == 1 && ring_used[0]) begin
            ring_high[0] = 1'b1;
            high_cnt++;
          end
        end
      end
      REQ_LOWER: begin
        s = find_slot(id);
        if (s < 0) begin
          res.status = STAT_NOTFOUND;
        end else if (ring_high[s]) begin
          ring_high[s] = 1'b0;
          drop_high_count();
          if (high_cnt == 1 && ring_used[0]) begin
            ring_high[0] = 1'b0;
            drop_high_count();
          end
        end
      end
      REQ_STOP, REQ_EXIT: begin
        s = find_slot(id);
        if (s < 0) begin
          res.status = STAT_NOTFOUND;
        end else begin
          cur      = s[SLOT_W-1:0];
          cur_slot = cur;
          nxt      = ring_next[cur];
          if (req == REQ_EXIT && nxt == cur) begin
            res.status = STAT_DEAD;     // last task left; ring untouched
          end else begin
            if (req == REQ_EXIT) begin
              pred = cur;
              for (int i = 0; i < MAX_TASKS; i++) begin
                if (ring_next[pred] == cur) break;
                pred = ring_next[pred];
              end
              ring_next[pred] = nxt;
              if (ring_high[cur]) drop_high_count();
              ring_used[cur] = 1'b0;
              ring_high[cur] = 1'b0;
            end
            cur_slot = pick_high_from(nxt);
            res.rid  = ring_id[cur_slot];
            res.run  = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int ring_population();
    int n;
    n = 0;
    for (int i = 0; i < MAX_TASKS; i++) if (ring_used[i]) n++;
    return n;
  endfunction

  // id of a random live task (the ring never empties)
  function automatic logic [ID_W-1:0] pick_live_id();
    int k;
    k = $urandom_range(ring_population() - 1);
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (ring_used[i]) begin
        if (k == 0) return ring_id[i];
        k--;
      end
    end
    return '0;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Send one request beat. start stays high on return so back-to-back beats
  // keep it up; an idle gap lowers it first.
  task automatic issue_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start      <= 1'b1;
    req_type_i <= req;
    task_id_i  <= id;
    do @(posedge clk_i); while (busy !== 1'b0);
    // beat taken at this edge
    pending_res_q.push_back(predict_request(req, id));
    beats_sent++;
    req_count[req]++;
  endtask

  // Stop sending until every owed result beat is in.
  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_res_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Ring holding only the shell: lookup hits, exit is refused, stop reruns it.
  task automatic test_shell_alone();
    issue_request(REQ_KILL, 8'h00);
    issue_request(REQ_EXIT, 8'h00);
    issue_request(REQ_STOP, 8'h00);
  endtask

  // Every lookup-based request on an id that is not in the ring, plus the
  // request codes the block ignores.
  task automatic test_unknown_and_spare();
    issue_request(REQ_KILL,  8'hFF);
    issue_request(REQ_RAISE, 8'hFF);
    issue_request(REQ_LOWER, 8'hFF);
    issue_request(REQ_STOP,  8'hFF);
    issue_request(REQ_EXIT,  8'hFF);
    issue_request(REQ_SPARE_LO, 8'hA5);
    issue_request(REQ_SPARE_HI, 8'h5A);
  endtask

  // First raise lifts the shell, repeated raise is a no-op, last lower drops
  // the shell, raising the shell itself counts it twice.
  task automatic test_priority_levels();
    issue_request(REQ_CREATE, 8'hFF);
    issue_request(REQ_CREATE, 8'h01);
    issue_request(REQ_RAISE,  8'hFF);
    issue_request(REQ_RAISE,  8'hFF);
    issue_request(REQ_STOP,   8'h01);   // next high after 01 is the shell
    issue_request(REQ_LOWER,  8'hFF);
    issue_request(REQ_RAISE,  8'h00);
    issue_request(REQ_LOWER,  8'h00);
  endtask

  // Exit picks the next high task past the leaver, a high task exiting
  // drops the count, and the last one standing cannot exit.
  task automatic test_exit_selection();
    issue_request(REQ_RAISE, 8'h01);
    issue_request(REQ_EXIT,  8'hFF);
    issue_request(REQ_EXIT,  8'h01);
    issue_request(REQ_EXIT,  8'h00);
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic: mostly requests on live ids, with bursts that fill the
  // ring past full and bursts that exit everything down to the last task.
  // ---------------------------------------------------------------------------
  task automatic test_random_traffic(int n_items);
    int              stop_at;
    int              roll;
    logic [ID_W-1:0] id;
    stop_at = beats_sent + n_items;
    while (beats_sent < stop_at) begin
      roll = $urandom_range(199);
      if (roll < 5) begin
        while (ring_population() < MAX_TASKS) begin
          id = $urandom_range(255);
          issue_request(REQ_CREATE, id);
        end
        id = $urandom_range(255);
        issue_request(REQ_CREATE, id);      // refused: ring full
      end else if (roll < 9) begin
        while (ring_population() > 1) issue_request(REQ_EXIT, pick_live_id());
        issue_request(REQ_EXIT, pick_live_id()); // refused: last task
      end else if (roll < 11) begin
        hold_until_drained();
      end else begin
        roll = $urandom_range(99);
        // mostly live ids, some random ones that usually miss
        if ($urandom_range(6) == 0) id = $urandom_range(255);
        else id = pick_live_id();
        if (roll < 28) begin
          if ($urandom_range(9) != 0) id = $urandom_range(255);
          issue_request(REQ_CREATE, id);    // else a duplicate id
        end else if (roll < 38) issue_request(REQ_KILL, id);
        else if (roll < 53) issue_request(REQ_RAISE, id);
        else if (roll < 66) issue_request(REQ_LOWER, id);
        else if (roll < 80) issue_request(REQ_STOP, id);
        else if (roll < 97) issue_request(REQ_EXIT, id);
        else issue_request($urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO, id);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: each done_o beat against the oldest owed result.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    sched_res_t got;
    sched_res_t want;
    if (rst_ni && done_o === 1'b1) begin
      got.status = status_o;
      got.rid    = result_id_o;
      got.run    = run_valid_o;
      results_seen++;
      status_count[got.status]++;
      if (pending_res_q.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("%t: result beat with nothing owed: status %0d id %0d run %0d",
                   $realtime, got.status, got.rid, got.run);
      end else begin
        want = pending_res_q.pop_front();
        if (got.status !== want.status || got.rid !== want.rid || got.run !== want.run) begin
          bad_results++;
          if (bad_results <= 10)
            $display("%t: result mismatch: expected status %0d id %0d run %0d, got %0d %0d %0d",
                     $realtime, want.status, want.rid, want.run,
                     got.status, got.rid, got.run);
        end
      end
    end
  end

  // Watchdog: any beat in either direction counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy === 1'b0) || done_o === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no beat for %0d cycles, %0d results owed",
                 QUIET_LIMIT, pending_res_q.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    // ring after reset: shell alone in slot 0, low, linked to itself
    for (int i = 0; i < MAX_TASKS; i++) begin
      ring_used[i] = 1'b0;
      ring_id[i]   = '0;
      ring_high[i] = 1'b0;
      ring_next[i] = '0;
    end
    ring_used[0] = 1'b1;
    cur_slot     = '0;
    high_cnt     = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 29;
    test_shell_alone();
    test_unknown_and_spare();
    test_priority_levels();
    test_exit_selection();
    hold_until_drained();

    test_random_traffic(310);
    hold_until_drained();
    idle_pct = 50;
    test_random_traffic(310);
    hold_until_drained();
    idle_pct = 0;
    test_random_traffic(308);

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);   // catch stray result beats

    $display("summary: %0d requests (create %0d kill %0d raise %0d lower %0d stop %0d exit %0d spare %0d)",
             beats_sent, req_count[REQ_CREATE], req_count[REQ_KILL], req_count[REQ_RAISE],
             req_count[REQ_LOWER], req_count[REQ_STOP], req_count[REQ_EXIT],
             req_count[REQ_SPARE_LO] + req_count[REQ_SPARE_HI]);
    $display("summary: %0d results (ok %0d, not found %0d, all dead %0d, ring full %0d), %0d bad",
             results_seen, status_count[STAT_OK], status_count[STAT_NOTFOUND],
             status_count[STAT_DEAD], status_count[STAT_FULL], bad_results);
    if (bad_results == 0 && pending_res_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: priority_round_robin_task_ring_core.f
+incdir+hdl
hdl/prrt_pkg.sv
hdl/prrt_table.sv
hdl/priority_round_robin_task_ring_core.sv
tb/sv/tb.sv
